// ----- src/qdf_pkg.sv -----
// ----------------------------------------------------------------------------
// qdf_pkg
// Shared types, constants and the coefficient function of the quarter-rate
// I/Q downconverter with its lowpass FIR.
// ----------------------------------------------------------------------------
package qdf_pkg;

   localparam int TAP_COUNT_DEF  = 63;
   localparam int COEF_WIDTH_DEF = 18;
   localparam int SAMPLE_W       = 16;
   localparam int MIX_W          = 18;
   localparam int RES_W          = 18;
   localparam int PROTO_LEN      = 32;
   localparam int PROTO_FRAC     = 17;

   localparam int PROTO_Q17 [PROTO_LEN] = '{
      32827, 29485, 20701, 9644, 0, -5569, -6392, -3754,
      0, 2698, 3274, 1995, 0, -1490, -1820, -1110,
      0, 818, 986, 591, 0, -418, -491, -287,
      0, 192, 222, 128, 0, -91, -115, -76
   };

   typedef struct packed {
      logic signed [MIX_W-1:0] i_val;
      logic signed [MIX_W-1:0] q_val;
      logic                    emit;
      logic                    fin;
      logic                    clear;
   } op_type;

   // Coefficient of one tap, rescaled from Q1.17 to cw-1 fraction bits.
   function automatic int tap_coef(int taps, int cw, int idx);
      int d;
      int v;
      d = idx - taps / 2;
      if (d < 0) begin
         d = -d;
      end
      v = (d < PROTO_LEN) ? PROTO_Q17[d] : 0;
      if (cw > PROTO_FRAC + 1) begin
         v = v <<< (cw - PROTO_FRAC - 1);
      end else if (cw < PROTO_FRAC + 1) begin
         v = (v + (1 <<< (PROTO_FRAC - cw))) >>> (PROTO_FRAC + 1 - cw);
      end
      return v;
   endfunction

endpackage

// ----- src/qdf_front.sv -----
// ----------------------------------------------------------------------------
// qdf_front
// Accepts samples, mixes them to baseband and issues one filter operation
// per sample, then the zero operations that flush a burst after its last word.
// ----------------------------------------------------------------------------
module qdf_front #(
   parameter int TAP_COUNT = qdf_pkg::TAP_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [qdf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_last,
   input  logic                                 q_full,
   output logic                                 q_push,
   output qdf_pkg::op_type                      q_op
);

   localparam int HALF = TAP_COUNT / 2;
   localparam int SW   = $clog2(HALF + 2);
   localparam int TW   = SW + 1;

   logic [1:0]    phase_ff, phase_in;
   logic [SW-1:0] seen_ff, seen_in, seen_inc;
   logic [SW-1:0] base_ff, base_in;
   logic [SW-1:0] tcnt_ff, tcnt_in;
   logic          flush_ff, flush_in;
   logic          take;
   logic signed [qdf_pkg::MIX_W-1:0] m2;

   assign req_stall = flush_ff | q_full;
   assign take      = req_valid & ~req_stall;
   assign m2        = qdf_pkg::MIX_W'(req_sample) <<< 1;
   assign seen_inc  = (seen_ff < SW'(HALF + 1)) ? seen_ff + SW'(1) : seen_ff;

   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      base_in  = base_ff;
      tcnt_in  = tcnt_ff;
      flush_in = flush_ff;
      q_push   = 1'b0;
      q_op     = '0;
      if (take) begin
         q_push   = 1'b1;
         phase_in = phase_ff + 2'd1;
         seen_in  = seen_inc;
         unique case (phase_ff)
            2'd0:    q_op.i_val = m2;
            2'd1:    q_op.q_val = m2;
            2'd2:    q_op.i_val = -m2;
            default: q_op.q_val = -m2;
         endcase
         q_op.emit = (seen_inc == SW'(HALF + 1));
         if (req_last) begin
            flush_in = 1'b1;
            tcnt_in  = SW'(1);
            base_in  = seen_inc;
         end
      end else if (flush_ff && !q_full) begin
         q_push     = 1'b1;
         q_op.emit  = (TW'(base_ff) + TW'(tcnt_ff)) >= TW'(HALF + 1);
         q_op.fin   = (tcnt_ff == SW'(HALF));
         q_op.clear = (tcnt_ff == SW'(HALF));
         if (tcnt_ff == SW'(HALF)) begin
            flush_in = 1'b0;
            phase_in = 2'd0;
            seen_in  = '0;
         end else begin
            tcnt_in = tcnt_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         seen_ff  <= '0;
         base_ff  <= '0;
         tcnt_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         base_ff  <= base_in;
         tcnt_ff  <= tcnt_in;
         flush_ff <= flush_in;
      end
   end

endmodule

// ----- src/qdf_queue.sv -----
// ----------------------------------------------------------------------------
// qdf_queue
// Four-entry queue of filter operations between the front and back parts.
// ----------------------------------------------------------------------------
module qdf_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  qdf_pkg::op_type push_op,
   input  logic            pop,
   output qdf_pkg::op_type head_op,
   output logic            full,
   output logic            empty
);

   qdf_pkg::op_type mem [4];
   logic [1:0] wptr_ff, rptr_ff;
   logic [2:0] cnt_ff;

   assign full    = (cnt_ff == 3'd4);
   assign empty   = (cnt_ff == 3'd0);
   assign head_op = mem[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 2'd1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + {2'b0, push} - {2'b0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Queue written while full.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("Queue read while empty.");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 3'd1)
      else $error("Queue count did not follow a write.");

endmodule

// ----- src/qdf_back.sv -----
// ----------------------------------------------------------------------------
// qdf_back
// Holds the mixed history and runs the pipelined FIR: one row of tap
// products, a registered tree of eight-input adders, then rounding and
// saturation into the output register.
// ----------------------------------------------------------------------------
module qdf_back #(
   parameter int TAP_COUNT  = qdf_pkg::TAP_COUNT_DEF,
   parameter int COEF_WIDTH = qdf_pkg::COEF_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  qdf_pkg::op_type                   head_op,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [qdf_pkg::RES_W-1:0]  rsp_in_phase,
   output logic signed [qdf_pkg::RES_W-1:0]  rsp_quadrature,
   output logic                              rsp_final_res
);

   localparam int MW   = qdf_pkg::MIX_W;
   localparam int AW   = COEF_WIDTH + MW + 8;
   localparam int LVLS = 3;
   localparam logic signed [AW-1:0] RND  = AW'(1) <<< (COEF_WIDTH - 2);
   localparam logic signed [AW-1:0] RMAX = AW'(131071);
   localparam logic signed [AW-1:0] RMIN = -AW'(131072);

   logic signed [MW-1:0] hist_ff [2][TAP_COUNT];
   logic signed [MW-1:0] hist_in [2][TAP_COUNT];
   logic signed [COEF_WIDTH-1:0] coef [TAP_COUNT];
   logic signed [AW-1:0] tree_ff [LVLS+1][2][TAP_COUNT];
   logic signed [AW-1:0] tree_in [LVLS+1][2][TAP_COUNT];
   logic [LVLS:0] vld_ff, fin_ff;
   logic          adv;
   logic signed [AW-1:0] rnd [2];
   logic signed [qdf_pkg::RES_W-1:0] sat [2];
   logic signed [qdf_pkg::RES_W-1:0] res_ff [2];
   logic          rvld_ff, rfin_ff;

   assign adv   = ~(rvld_ff & rsp_stall);
   assign q_pop = adv & ~q_empty;

   always_comb begin
      for (int i = 0; i < TAP_COUNT; i++) begin
         coef[i] = COEF_WIDTH'(qdf_pkg::tap_coef(TAP_COUNT, COEF_WIDTH, i));
      end
      for (int c = 0; c < 2; c++) begin
         hist_in[c][0] = (c == 0) ? head_op.i_val : head_op.q_val;
         for (int i = 1; i < TAP_COUNT; i++) begin
            hist_in[c][i] = hist_ff[c][i-1];
         end
         for (int i = 0; i < TAP_COUNT; i++) begin
            tree_in[0][c][i] = AW'(coef[i]) * AW'(hist_in[c][i]);
         end
         for (int l = 1; l <= LVLS; l++) begin
            for (int j = 0; j < TAP_COUNT; j++) begin
               tree_in[l][c][j] = '0;
               for (int k = 0; k < 8; k++) begin
                  if (8 * j + k < TAP_COUNT) begin
                     tree_in[l][c][j] = tree_in[l][c][j] + tree_ff[l-1][c][8*j+k];
                  end
               end
            end
         end
         rnd[c] = (tree_ff[LVLS][c][0] + RND) >>> (COEF_WIDTH - 1);
         if (rnd[c] > RMAX) begin
            sat[c] = qdf_pkg::RES_W'(RMAX);
         end else if (rnd[c] < RMIN) begin
            sat[c] = qdf_pkg::RES_W'(RMIN);
         end else begin
            sat[c] = qdf_pkg::RES_W'(rnd[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < TAP_COUNT; i++) begin
               hist_ff[c][i] <= '0;
            end
         end
      end else if (q_pop) begin
         for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < TAP_COUNT; i++) begin
               hist_ff[c][i] <= head_op.clear ? '0 : hist_in[c][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tree_ff[0] <= tree_in[0];
         for (int l = 1; l <= LVLS; l++) begin
            tree_ff[l] <= tree_in[l];
         end
         res_ff[0] <= sat[0];
         res_ff[1] <= sat[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         fin_ff  <= '0;
         rvld_ff <= 1'b0;
         rfin_ff <= 1'b0;
      end else if (adv) begin
         vld_ff  <= {vld_ff[LVLS-1:0], q_pop & head_op.emit};
         fin_ff  <= {fin_ff[LVLS-1:0], q_pop & head_op.fin};
         rvld_ff <= vld_ff[LVLS];
         rfin_ff <= fin_ff[LVLS];
      end
   end

   assign rsp_valid      = rvld_ff;
   assign rsp_in_phase   = res_ff[0];
   assign rsp_quadrature = res_ff[1];
   assign rsp_final_res  = rfin_ff;

   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_final_res |-> rsp_valid)
      else $error("Final flag shown without a valid word.");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> adv)
      else $error("Operation taken while the pipeline is held.");
   a_clear_hist: assert property (@(posedge clock) disable iff (reset)
      (q_pop && head_op.clear) |=> hist_ff[0][0] == '0 && hist_ff[1][0] == '0)
      else $error("History not cleared after the end of a burst.");

endmodule

// ----- src/quadrature_downconvert_fir_top.sv -----
// ----------------------------------------------------------------------------
// quadrature_downconvert_fir_top
// Quarter-rate I/Q downconverter followed by a centred lowpass FIR.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_sample[15:0], req_last
//   rsp      out        rsp_valid/stall    rsp_in_phase, rsp_quadrature,
//                                          rsp_final_res
//
// One sample is taken per cycle while req_stall is low; after a last word the
// front issues TAP_COUNT/2 flush operations, one per cycle while the queue is
// not full, and req_stall stays high meanwhile.
// Reset is synchronous and clears the history, the phase and the queue.
// A stall on rsp while a word waits holds the whole back pipeline; the queue
// keeps the front running until it fills.
// ----------------------------------------------------------------------------
module quadrature_downconvert_fir_top #(
   parameter int TAP_COUNT  = qdf_pkg::TAP_COUNT_DEF,
   parameter int COEF_WIDTH = qdf_pkg::COEF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [qdf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [qdf_pkg::RES_W-1:0]     rsp_in_phase,
   output logic signed [qdf_pkg::RES_W-1:0]     rsp_quadrature,
   output logic                                 rsp_final_res
);

   qdf_pkg::op_type push_op, head_op;
   logic q_push, q_pop, q_full, q_empty;

   qdf_front #(.TAP_COUNT(TAP_COUNT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_last   (req_last),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (push_op)
   );

   qdf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .pop     (q_pop),
      .head_op (head_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   qdf_back #(.TAP_COUNT(TAP_COUNT), .COEF_WIDTH(COEF_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .head_op        (head_op),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_in_phase   (rsp_in_phase),
      .rsp_quadrature (rsp_quadrature),
      .rsp_final_res  (rsp_final_res)
   );

endmodule
